FILE: sv/three_band_stereo_equalizer_assert.svh
// Assertion macros shared by the equalizer RTL.
// Clock is i_clk, reset is i_rst_n (active low); checks are off while reset is held.
`ifndef THREE_BAND_STEREO_EQUALIZER_ASSERT_SVH
`define THREE_BAND_STEREO_EQUALIZER_ASSERT_SVH

// Same-cycle implication
`define TBSE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define TBSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/tbse_pkg.sv
package tbse_pkg;

    // Block dimensions
    localparam int CHANNELS    = 2;
    localparam int SAMPLE_BITS = 16;
    localparam int STATE_BITS  = 32;
    localparam int OUT_CH      = 2;
    localparam int LANES       = (CHANNELS < OUT_CH) ? CHANNELS : OUT_CH;
    localparam int FRAC_EXT    = STATE_BITS - SAMPLE_BITS;

    // Register field widths
    localparam int COEF_W = 16;
    localparam int GAIN_W = 15;
    localparam int VOL_W  = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 5;
    localparam int IDX_W  = ADDR_W - 2;

    // Datapath widths
    localparam int DIFF_W = STATE_BITS + 1;
    localparam int FP_W   = DIFF_W + COEF_W + 1;
    localparam int G_W    = DIFF_W + GAIN_W + 1;
    localparam int SUM_W  = STATE_BITS + 4;
    localparam int Y_W    = SUM_W + VOL_W + 1;
    localparam int CL_W   = STATE_BITS + 1;
    localparam int PCM_W  = CL_W + SAMPLE_BITS;
    localparam int RND_W  = Y_W + SAMPLE_BITS;

    // Rounding shifts
    localparam int COEF_SHIFT = 16;
    localparam int GAIN_SHIFT = 14;
    localparam int VOL_SHIFT  = 15;
    localparam int PCM_SHIFT  = STATE_BITS - 1;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_LOW_COEF  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_HIGH_COEF = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_GAIN_LOW  = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_GAIN_MID  = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_GAIN_HIGH = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_VOLUME    = IDX_W'(5);

    // Register reset values
    localparam logic [COEF_W-1:0] RST_LOW_COEF  = COEF_W'(1815);
    localparam logic [COEF_W-1:0] RST_HIGH_COEF = COEF_W'(23776);
    localparam logic [GAIN_W-1:0] RST_GAIN      = GAIN_W'(16384);
    localparam logic [VOL_W-1:0]  RST_VOLUME    = VOL_W'(26214);

    // Saturation bounds and PCM full scale
    localparam logic signed [RND_W-1:0] FS_POS = RND_W'(1) << (STATE_BITS - 1);
    localparam logic signed [RND_W-1:0] FS_NEG = -FS_POS;
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [PCM_W-1:0]       t_pcm;

    typedef struct packed {
        logic [COEF_W-1:0] coef_lo;
        logic [COEF_W-1:0] coef_hi;
        logic [GAIN_W-1:0] gain_lo;
        logic [GAIN_W-1:0] gain_mid;
        logic [GAIN_W-1:0] gain_hi;
        logic [VOL_W-1:0]  volume;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILT,
        S_UPD,
        S_GAIN,
        S_SUM,
        S_VOL,
        S_PCM,
        S_OUT
    } t_eq_state;

    typedef struct packed {
        logic      load;
        logic      restart;
        t_eq_state step;
    } t_lane_ctl;

    // Arithmetic shift right by s, rounding halves away from zero
    function automatic logic signed [RND_W-1:0] rnd_shr(input logic signed [RND_W-1:0] p,
                                                        input int unsigned s);
        logic signed [RND_W-1:0] h;
        h = RND_W'(1) << (s - 1);
        if (p < 0) begin
            h = h - RND_W'(1);
        end
        return (p + h) >>> s;
    endfunction

endpackage

FILE: sv/tbse_regs.sv
module tbse_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tbse_pkg::ADDR_W-1:0]  paddr,
    input  logic [tbse_pkg::DATA_W-1:0]  pwdata,
    output logic [tbse_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output tbse_pkg::t_cfg               o_cfg
);
    import tbse_pkg::*;

    t_cfg             r_cfg;
    logic [IDX_W-1:0] w_idx;
    logic             w_wr;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Write the addressed register, drop writes past the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_lo  <= RST_LOW_COEF;
            r_cfg.coef_hi  <= RST_HIGH_COEF;
            r_cfg.gain_lo  <= RST_GAIN;
            r_cfg.gain_mid <= RST_GAIN;
            r_cfg.gain_hi  <= RST_GAIN;
            r_cfg.volume   <= RST_VOLUME;
        end else if (w_wr) begin
            case (w_idx)
                REG_LOW_COEF:  r_cfg.coef_lo  <= pwdata[COEF_W-1:0];
                REG_HIGH_COEF: r_cfg.coef_hi  <= pwdata[COEF_W-1:0];
                REG_GAIN_LOW:  r_cfg.gain_lo  <= pwdata[GAIN_W-1:0];
                REG_GAIN_MID:  r_cfg.gain_mid <= pwdata[GAIN_W-1:0];
                REG_GAIN_HIGH: r_cfg.gain_hi  <= pwdata[GAIN_W-1:0];
                REG_VOLUME:    r_cfg.volume   <= pwdata[VOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register
    always_comb begin
        case (w_idx)
            REG_LOW_COEF:  prdata = DATA_W'(r_cfg.coef_lo);
            REG_HIGH_COEF: prdata = DATA_W'(r_cfg.coef_hi);
            REG_GAIN_LOW:  prdata = DATA_W'(r_cfg.gain_lo);
            REG_GAIN_MID:  prdata = DATA_W'(r_cfg.gain_mid);
            REG_GAIN_HIGH: prdata = DATA_W'(r_cfg.gain_hi);
            REG_VOLUME:    prdata = DATA_W'(r_cfg.volume);
            default:       prdata = '0;
        endcase
    end

endmodule

FILE: sv/tbse_lane.sv
module tbse_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tbse_pkg::t_lane_ctl i_ctl,
    input  tbse_pkg::t_cfg      i_cfg,
    input  tbse_pkg::t_sample   i_sample,
    output tbse_pkg::t_pcm      o_pcm
);
    import tbse_pkg::*;

    // Filter states and per-step registers
    logic signed [STATE_BITS-1:0] r_low, r_xo, n_low, n_xo;
    t_sample                      r_x;
    logic signed [FP_W-1:0]       r_p_lo, r_p_hi, n_p_lo, n_p_hi;
    logic signed [G_W-1:0]        r_g_lo, r_g_mid, r_g_hi, n_g_lo, n_g_mid, n_g_hi;
    logic signed [SUM_W-1:0]      r_sum, n_sum;
    logic signed [Y_W-1:0]        r_y, n_y;
    t_pcm                         r_pcm, n_pcm;

    logic signed [STATE_BITS-1:0] w_xs;
    logic signed [DIFF_W-1:0]     w_d_lo, w_d_hi, w_band_lo, w_band_mid, w_band_hi;
    logic signed [RND_W-1:0]      w_rf_lo, w_rf_hi, w_rg_lo, w_rg_mid, w_rg_hi, w_yr;
    logic signed [CL_W-1:0]       w_cl;

    assign w_xs  = {r_x, {FRAC_EXT{1'b0}}};
    assign o_pcm = r_pcm;

    // Filter products: coefficient times distance to the sample
    always_comb begin
        w_d_lo = DIFF_W'(w_xs) - DIFF_W'(r_low);
        w_d_hi = DIFF_W'(w_xs) - DIFF_W'(r_xo);
        n_p_lo = FP_W'(w_d_lo) * FP_W'($signed({1'b0, i_cfg.coef_lo}));
        n_p_hi = FP_W'(w_d_hi) * FP_W'($signed({1'b0, i_cfg.coef_hi}));
    end

    // State update with rounded step
    always_comb begin
        w_rf_lo = rnd_shr(RND_W'(r_p_lo), COEF_SHIFT);
        w_rf_hi = rnd_shr(RND_W'(r_p_hi), COEF_SHIFT);
        n_low   = r_low + w_rf_lo[STATE_BITS-1:0];
        n_xo    = r_xo + w_rf_hi[STATE_BITS-1:0];
    end

    // Band split and gain products
    always_comb begin
        w_band_lo  = DIFF_W'(r_low);
        w_band_mid = DIFF_W'(r_xo) - DIFF_W'(r_low);
        w_band_hi  = DIFF_W'(w_xs) - DIFF_W'(r_xo);
        n_g_lo     = G_W'(w_band_lo) * G_W'($signed({1'b0, i_cfg.gain_lo}));
        n_g_mid    = G_W'(w_band_mid) * G_W'($signed({1'b0, i_cfg.gain_mid}));
        n_g_hi     = G_W'(w_band_hi) * G_W'($signed({1'b0, i_cfg.gain_hi}));
    end

    // Sum of rounded band terms, then volume product
    always_comb begin
        w_rg_lo  = rnd_shr(RND_W'(r_g_lo), GAIN_SHIFT);
        w_rg_mid = rnd_shr(RND_W'(r_g_mid), GAIN_SHIFT);
        w_rg_hi  = rnd_shr(RND_W'(r_g_hi), GAIN_SHIFT);
        n_sum    = w_rg_lo[SUM_W-1:0] + w_rg_mid[SUM_W-1:0] + w_rg_hi[SUM_W-1:0];
        n_y      = Y_W'(r_sum) * Y_W'($signed({1'b0, i_cfg.volume}));
    end

    // Saturate to full scale and scale to PCM
    always_comb begin
        w_yr = rnd_shr(RND_W'(r_y), VOL_SHIFT);
        if (w_yr > FS_POS) begin
            w_cl = FS_POS[CL_W-1:0];
        end else if (w_yr < FS_NEG) begin
            w_cl = FS_NEG[CL_W-1:0];
        end else begin
            w_cl = w_yr[CL_W-1:0];
        end
        n_pcm = PCM_W'(w_cl) * PCM_W'(OUT_MAX);
    end

    // Filter states: clear on reset or restart, advance once per frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low <= '0;
            r_xo  <= '0;
        end else if (i_ctl.load && i_ctl.restart) begin
            r_low <= '0;
            r_xo  <= '0;
        end else if (i_ctl.step == S_UPD) begin
            r_low <= n_low;
            r_xo  <= n_xo;
        end
    end

    // Working registers, one step per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x <= i_sample;
        end
        case (i_ctl.step)
            S_FILT: begin
                r_p_lo <= n_p_lo;
                r_p_hi <= n_p_hi;
            end
            S_GAIN: begin
                r_g_lo  <= n_g_lo;
                r_g_mid <= n_g_mid;
                r_g_hi  <= n_g_hi;
            end
            S_SUM:   r_sum <= n_sum;
            S_VOL:   r_y   <= n_y;
            S_PCM:   r_pcm <= n_pcm;
            default: ;
        endcase
    end

endmodule

FILE: sv/tbse_merge.sv
module tbse_merge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  tbse_pkg::t_pcm    i_pcm [tbse_pkg::LANES],
    input  logic              i_stall,
    output logic              o_valid,
    output logic              o_free,
    output tbse_pkg::t_sample o_out [tbse_pkg::OUT_CH]
);
    import tbse_pkg::*;

    logic    r_valid;
    t_sample r_out [OUT_CH];
    t_sample n_out [OUT_CH];

    assign o_valid = r_valid;
    assign o_free  = !r_valid || !i_stall;

    // Round each lane to PCM; unused outputs read zero
    for (genvar gc = 0; gc < OUT_CH; gc++) begin : g_out
        if (gc < LANES) begin : g_lane
            logic signed [RND_W-1:0] w_r;
            assign w_r       = rnd_shr(RND_W'(i_pcm[gc]), PCM_SHIFT);
            assign n_out[gc] = w_r[SAMPLE_BITS-1:0];
        end else begin : g_zero
            assign n_out[gc] = '0;
        end
        assign o_out[gc] = r_out[gc];
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: sv/three_band_stereo_equalizer.sv
// Three-band stereo equalizer: each request is one stereo frame (restart flag plus
// a signed 16-bit sample per channel) and yields one equalized frame. One lane per
// channel runs the two one-pole filters, band split, gains, volume, saturation and
// PCM scaling as six registered steps, and an output register merges the lanes.
// A frame passes six steps and an output state before its result is shown, and a
// new request is taken only as the last frame leaves the output state. The result
// register lets the next request enter while a result waits. Registers sit on an APB
// port at byte addresses 0x00 to 0x14; write them only while the block is idle. A
// restart request clears both filter states first.
`include "three_band_stereo_equalizer_assert.svh"

module three_band_stereo_equalizer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tbse_pkg::ADDR_W-1:0]  paddr,
    input  logic [tbse_pkg::DATA_W-1:0]  pwdata,
    output logic [tbse_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_restart,
    input  tbse_pkg::t_sample            i_left_in,
    input  tbse_pkg::t_sample            i_right_in,
    output logic                         o_valid,
    input  logic                         i_stall,
    output tbse_pkg::t_sample            o_left_out,
    output tbse_pkg::t_sample            o_right_out
);
    import tbse_pkg::*;

    t_eq_state r_state, n_state;
    t_lane_ctl w_ctl;
    t_cfg      w_cfg;
    logic      w_mrg_load;
    logic      w_free;
    t_sample   w_in  [OUT_CH];
    t_sample   w_out [OUT_CH];
    t_pcm      w_pcm [LANES];

    assign w_in[0]     = i_left_in;
    assign w_in[1]     = i_right_in;
    assign o_left_out  = w_out[0];
    assign o_right_out = w_out[1];

    tbse_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // One lane per channel
    for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
        tbse_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_cfg    (w_cfg),
            .i_sample (w_in[gl]),
            .o_pcm    (w_pcm[gl])
        );
    end

    tbse_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_mrg_load),
        .i_pcm   (w_pcm),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_free  (w_free),
        .o_out   (w_out)
    );

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Step the lanes; take a request when idle or while handing off a result
    always_comb begin
        n_state       = r_state;
        w_ctl.load    = 1'b0;
        w_ctl.restart = i_restart;
        w_ctl.step    = r_state;
        w_mrg_load    = 1'b0;
        o_stall       = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    w_ctl.load = 1'b1;
                    n_state    = S_FILT;
                end
            end
            S_FILT: n_state = S_UPD;
            S_UPD:  n_state = S_GAIN;
            S_GAIN: n_state = S_SUM;
            S_SUM:  n_state = S_VOL;
            S_VOL:  n_state = S_PCM;
            S_PCM:  n_state = S_OUT;
            S_OUT: begin
                if (w_free) begin
                    w_mrg_load = 1'b1;
                    o_stall    = 1'b0;
                    if (i_valid) begin
                        w_ctl.load = 1'b1;
                        n_state    = S_FILT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `TBSE_ASSERT_SAME(a_accept_state, i_valid && !o_stall, r_state == S_IDLE || r_state == S_OUT, "request taken while a frame is in flight")
    `TBSE_ASSERT_NEXT(a_accept_start, i_valid && !o_stall, r_state == S_FILT, "accepted frame did not start filtering")
    `TBSE_ASSERT_NEXT(a_filt_upd, r_state == S_FILT, r_state == S_UPD, "filter product not followed by state update")
    `TBSE_ASSERT_NEXT(a_result_shown, r_state == S_OUT && w_free, o_valid, "finished frame not presented")

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import tbse_pkg::*;

    // Addresses with no register behind them
    localparam logic [IDX_W-1:0] REG_SPARE_LO = IDX_W'(6);
    localparam logic [IDX_W-1:0] REG_SPARE_HI = IDX_W'(7);

    localparam longint STATE_FS = longint'(1) << (STATE_BITS - 1);
    localparam logic [COEF_W-1:0] COEF_MAX = '1;
    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
    localparam logic [VOL_W-1:0] VOL_MAX = '1;
    localparam logic [VOL_W-1:0] VOL_UNITY = VOL_W'(32768);
    localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(16384);

    typedef struct {
        t_sample left;
        t_sample right;
    } t_frame_out;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_valid;
    logic                o_stall;
    logic                i_restart;
    t_sample             i_left_in;
    t_sample             i_right_in;
    logic                o_valid;
    logic                i_stall;
    t_sample             o_left_out;
    t_sample             o_right_out;

    // Shadow of the register file and of the filter states
    t_cfg        eq_cfg;
    longint      low_band[CHANNELS];
    longint      crossover[CHANNELS];
    t_frame_out  pending_frames[$];
    int unsigned error_count;

    // Idle controls shared by the sender and the receiver
    bit tx_gaps;
    bit rx_stalls;
    int rx_hold_req;

    three_band_stereo_equalizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_restart   (i_restart),
        .i_left_in   (i_left_in),
        .i_right_in  (i_right_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_left_out  (o_left_out),
        .o_right_out (o_right_out)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Product shifted right by s, halves rounded away from zero
    function automatic longint round_shift_mul(input longint v, input longint k, input int s);
        longint mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r = (mag * k + (longint'(1) << (s - 1))) >>> s;
        return (v < 0) ? -r : r;
    endfunction

    // Advance one channel's filters and return its equalized PCM sample
    function automatic t_sample equalize_channel(input int ch, input t_sample x);
        longint xs;
        longint mid;
        longint high;
        longint sum;
        longint y;
        longint mag;
        longint pcm;
        xs = longint'(x) <<< FRAC_EXT;
        low_band[ch] += round_shift_mul(xs - low_band[ch], longint'(eq_cfg.coef_lo),
                                        COEF_SHIFT);
        crossover[ch] += round_shift_mul(xs - crossover[ch], longint'(eq_cfg.coef_hi),
                                         COEF_SHIFT);
        mid = crossover[ch] - low_band[ch];
        high = xs - crossover[ch];
        sum = round_shift_mul(low_band[ch], longint'(eq_cfg.gain_lo), GAIN_SHIFT)
            + round_shift_mul(mid, longint'(eq_cfg.gain_mid), GAIN_SHIFT)
            + round_shift_mul(high, longint'(eq_cfg.gain_hi), GAIN_SHIFT);
        y = round_shift_mul(sum, longint'(eq_cfg.volume), VOL_SHIFT);
        if (y > STATE_FS) begin
            y = STATE_FS;
        end else if (y < -STATE_FS) begin
            y = -STATE_FS;
        end
        mag = (y < 0) ? -y : y;
        pcm = (mag * longint'(OUT_MAX) + (STATE_FS >>> 1)) >>> PCM_SHIFT;
        return t_sample'((y < 0) ? -pcm : pcm);
    endfunction

    function automatic t_frame_out equalize_frame(input logic restart, input t_sample left,
                                                  input t_sample right);
        t_frame_out res;
        if (restart) begin
            for (int c = 0; c < CHANNELS; c++) begin
                low_band[c] = 0;
                crossover[c] = 0;
            end
        end
        res.left = equalize_channel(0, left);
        res.right = (CHANNELS > 1) ? equalize_channel(1, right) : t_sample'(0);
        return res;
    endfunction

    // Mostly back-to-back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int r;
        if (!tx_gaps) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_sample rand_sample();
        case ($urandom_range(0, 9))
            0: return ($urandom_range(0, 1) != 0) ? t_sample'(16'sh7fff) : t_sample'(16'sh8000);
            1, 2: return t_sample'(int'($urandom_range(0, 511)) - 256);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_level(input logic [15:0] top);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return top;
            default: return 16'($urandom_range(0, int'(top)));
        endcase
    endfunction

    function automatic t_cfg rand_cfg();
        t_cfg c;
        c.coef_lo = pick_level(COEF_MAX);
        c.coef_hi = pick_level(COEF_MAX);
        c.gain_lo = GAIN_W'(pick_level(16'(GAIN_MAX)));
        c.gain_mid = GAIN_W'(pick_level(16'(GAIN_MAX)));
        c.gain_hi = GAIN_W'(pick_level(16'(GAIN_MAX)));
        c.volume = pick_level(VOL_MAX);
        return c;
    endfunction

    // Offer one request, hold it until taken, then idle for a random gap
    task automatic send_frame(input logic restart, input t_sample left, input t_sample right);
        int gap;
        i_valid <= 1'b1;
        i_restart <= restart;
        i_left_in <= left;
        i_right_in <= right;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_frames.push_back(equalize_frame(restart, left, right));
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic stop_offering();
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup cycle, access cycle, then release the bus
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_LOW_COEF:  eq_cfg.coef_lo = value[COEF_W-1:0];
            REG_HIGH_COEF: eq_cfg.coef_hi = value[COEF_W-1:0];
            REG_GAIN_LOW:  eq_cfg.gain_lo = value[GAIN_W-1:0];
            REG_GAIN_MID:  eq_cfg.gain_mid = value[GAIN_W-1:0];
            REG_GAIN_HIGH: eq_cfg.gain_hi = value[GAIN_W-1:0];
            REG_VOLUME:    eq_cfg.volume = value[VOL_W-1:0];
            default: ;
        endcase
    endtask

    // Drain the block, then load every register
    task automatic configure(input t_cfg c);
        stop_offering();
        wait_drained();
        write_reg(REG_LOW_COEF, DATA_W'(c.coef_lo));
        write_reg(REG_HIGH_COEF, DATA_W'(c.coef_hi));
        write_reg(REG_GAIN_LOW, DATA_W'(c.gain_lo));
        write_reg(REG_GAIN_MID, DATA_W'(c.gain_mid));
        write_reg(REG_GAIN_HIGH, DATA_W'(c.gain_hi));
        write_reg(REG_VOLUME, DATA_W'(c.volume));
    endtask

    // One stretch of audio-like input: noise, DC, square, ramp or noisy DC
    task automatic send_segment(input int count);
        int kind;
        int period;
        t_sample base_l;
        t_sample base_r;
        t_sample l;
        t_sample r;
        logic rst;
        kind = $urandom_range(0, 4);
        period = $urandom_range(1, 16);
        base_l = rand_sample();
        base_r = rand_sample();
        for (int k = 0; k < count; k++) begin
            rst = ($urandom_range(0, 39) == 0);
            case (kind)
                0: begin
                    l = rand_sample();
                    r = rand_sample();
                end
                1: begin
                    l = base_l;
                    r = base_r;
                end
                2: begin
                    l = ((k / period) % 2 != 0) ? -base_l : base_l;
                    r = ((k / period) % 2 != 0) ? base_r : -base_r;
                end
                3: begin
                    l = base_l + t_sample'(k * 613);
                    r = base_r - t_sample'(k * 977);
                end
                default: begin
                    l = base_l + t_sample'(int'($urandom_range(0, 63)) - 32);
                    r = base_r + t_sample'(int'($urandom_range(0, 63)) - 32);
                end
            endcase
            send_frame(rst, l, r);
        end
    endtask

    task automatic send_items(input int total);
        int sent;
        int n;
        sent = 0;
        while (sent < total) begin
            n = $urandom_range(10, 60);
            if (n > total - sent) begin
                n = total - sent;
            end
            send_segment(n);
            sent += n;
        end
    endtask

    // Reset settings: sample extremes, sign flips and restarts
    task automatic test_reset_settings();
        send_frame(1'b1, 16'sd0, 16'sd0);
        send_frame(1'b0, 16'sh7fff, 16'sh8000);
        send_frame(1'b0, 16'sh7fff, 16'sh8000);
        send_frame(1'b0, 16'sh8000, 16'sh7fff);
        send_frame(1'b0, -16'sd1, 16'sd1);
        send_frame(1'b0, 16'sd1, -16'sd1);
        send_frame(1'b1, 16'sh8000, 16'sh8000);
        send_frame(1'b0, 16'sh5555, 16'shaaaa);
        send_frame(1'b0, 16'sd0, 16'sd0);
    endtask

    // Top gains and volume with alternating full scale drive into clamping
    task automatic test_saturation();
        t_cfg c;
        c = '{coef_lo: COEF_MAX, coef_hi: 16'd20000, gain_lo: GAIN_MAX, gain_mid: GAIN_MAX,
              gain_hi: GAIN_MAX, volume: VOL_MAX};
        configure(c);
        send_frame(1'b1, 16'sh7fff, 16'sh8000);
        send_frame(1'b0, 16'sh8000, 16'sh7fff);
        send_frame(1'b0, 16'sh7fff, 16'sh8000);
        send_frame(1'b0, 16'sh8000, 16'sh7fff);
        send_frame(1'b1, 16'sh8000, 16'sh8000);
        send_frame(1'b0, 16'sh7fff, 16'sh7fff);
    endtask

    // Writes to unused addresses must leave the settings alone
    task automatic test_unused_address();
        stop_offering();
        wait_drained();
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        send_frame(1'b1, 16'sh7fff, 16'sh8000);
        send_frame(1'b0, 16'sh1234, -16'sh1234);
        send_frame(1'b0, 16'sh8000, 16'sh7fff);
        send_frame(1'b0, -16'sd2, 16'sd3);
    endtask

    // Walk through extreme and random register settings
    task automatic test_setting_sweep();
        t_cfg sweep[6];
        sweep[0] = '{coef_lo: '0, coef_hi: '0, gain_lo: '0, gain_mid: '0, gain_hi: '0,
                     volume: '0};
        sweep[1] = '{coef_lo: COEF_MAX, coef_hi: COEF_MAX, gain_lo: GAIN_MAX,
                     gain_mid: GAIN_MAX, gain_hi: GAIN_MAX, volume: VOL_MAX};
        sweep[2] = '{coef_lo: '0, coef_hi: COEF_MAX, gain_lo: GAIN_UNITY,
                     gain_mid: GAIN_UNITY, gain_hi: GAIN_UNITY, volume: VOL_UNITY};
        sweep[3] = '{coef_lo: COEF_MAX, coef_hi: '0, gain_lo: GAIN_MAX, gain_mid: '0,
                     gain_hi: '0, volume: VOL_UNITY};
        sweep[4] = rand_cfg();
        sweep[5] = rand_cfg();
        foreach (sweep[i]) begin
            configure(sweep[i]);
            send_items(120);
        end
    endtask

    // Hold the output off while requests keep coming, then wait for the backlog
    task automatic test_backpressure();
        configure(rand_cfg());
        tx_gaps = 1'b0;
        rx_hold_req = 300;
        send_items(40);
        tx_gaps = 1'b1;
        stop_offering();
        wait_drained();
    endtask

    // Random settings with every mix of sender and receiver idling
    task automatic test_random_stream();
        for (int phase = 0; phase < 8; phase++) begin
            configure(rand_cfg());
            tx_gaps = phase[0] | phase[2];
            rx_stalls = phase[1] | phase[2];
            send_items(40);
            if ($urandom_range(0, 2) == 0) begin
                stop_offering();
                wait_drained();
            end
            send_items(40);
        end
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
    endtask

    // Receiver stall: random runs, plus a long hold when asked for
    initial begin : rx_stall_drive
        int run_left;
        int hold_left;
        run_left = 0;
        hold_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req > 0) begin
                hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
                run_left = 0;
            end else if (!rx_stalls) begin
                i_stall <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: begin
                        i_stall <= 1'b0;
                        run_left = $urandom_range(0, 7);
                    end
                    6, 7, 8: begin
                        i_stall <= 1'b1;
                        run_left = $urandom_range(0, 2);
                    end
                    default: begin
                        i_stall <= 1'b1;
                        run_left = $urandom_range(10, 40);
                    end
                endcase
            end
        end
    end

    // Compare each taken result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_frame_out exp_f;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_frames.size() == 0) begin
                $display("%0t: unexpected result, left_out %0d right_out %0d",
                         $time, o_left_out, o_right_out);
                error_count++;
            end else begin
                exp_f = pending_frames.pop_front();
                if (o_left_out !== exp_f.left) begin
                    $display("%0t: left_out mismatch, expected %0d, got %0d",
                             $time, exp_f.left, o_left_out);
                    error_count++;
                end
                if (o_right_out !== exp_f.right) begin
                    $display("%0t: right_out mismatch, expected %0d, got %0d",
                             $time, exp_f.right, o_right_out);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #15000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_restart <= 1'b0;
        i_left_in <= '0;
        i_right_in <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        rx_hold_req = 0;
        error_count = 0;
        eq_cfg = '{coef_lo: RST_LOW_COEF, coef_hi: RST_HIGH_COEF, gain_lo: RST_GAIN,
                   gain_mid: RST_GAIN, gain_hi: RST_GAIN, volume: RST_VOLUME};
        for (int c = 0; c < CHANNELS; c++) begin
            low_band[c] = 0;
            crossover[c] = 0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_settings();
        test_saturation();
        test_unused_address();
        test_setting_sweep();
        test_backpressure();
        test_random_stream();

        stop_offering();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
